### hw/rtl/dpht_pkg.sv
// Shared types and codes for the depth-preferred hash table core.
// No dependencies; imported by the controller, datapath and top level.
package dpht_pkg;

   localparam int KeyWidth   = 64;
   localparam int DepthWidth = 7;
   localparam int ScoreWidth = 16;
   localparam int BoundWidth = 2;
   localparam int MoveWidth  = 8;
   localparam int HitsWidth  = 32;

   // action codes
   localparam logic [1:0] ACT_PROBE = 2'd0;
   localparam logic [1:0] ACT_STORE = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_WIPE,
      ST_EVAL
   } state_type;

   // one table slot as held in memory
   typedef struct packed {
      logic                         valid;
      logic [KeyWidth-1:0]          key;
      logic [DepthWidth-1:0]        depth;
      logic signed [ScoreWidth-1:0] score;
      logic [BoundWidth-1:0]        bound;
      logic signed [MoveWidth-1:0]  move;
   } slot_type;

   typedef struct packed {
      logic accept;      // latch request and read its slot
      logic sweep;       // invalidate slot at sweep pointer, advance it
      logic commit;      // evaluate, update slot/counter, load result
      logic clear_hits;  // zero the hit counter
   } cmd_type;

   typedef struct packed {
      logic sweep_last;  // sweep pointer is at the last slot
      logic out_busy;    // result register holds an untaken beat
   } status_type;

endpackage

### hw/rtl/dpht_ctrl.sv
// Controller state machine for the depth-preferred hash table core.
// Depends on dpht_pkg; drives dpht_datapath through cmd_type/status_type.
module dpht_ctrl
   import dpht_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_action,
   output logic       req_ready,
   output cmd_type    cmd,
   input  status_type status
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_INIT: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_action == ACT_CLEAR) begin
                  cmd.clear_hits = 1'b1;
                  state_in       = ST_WIPE;
               end else begin
                  state_in = ST_EVAL;
               end
            end
         end
         ST_WIPE: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            // wait for the result register before touching the table
            if (!status.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

endmodule

### hw/rtl/dpht_datapath.sv
// Datapath for the depth-preferred hash table core: slot memory, request
// and result registers, hit counter, sweep pointer. Depends on dpht_pkg.
module dpht_datapath
   import dpht_pkg::*;
#(
   parameter int INDEX_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   output status_type                    status,
   input  logic [1:0]                    req_action,
   input  logic [KeyWidth-1:0]           req_position_key,
   input  logic [DepthWidth-1:0]         req_search_depth,
   input  logic signed [ScoreWidth-1:0]  req_score_value,
   input  logic [BoundWidth-1:0]         req_bound_kind,
   input  logic signed [MoveWidth-1:0]   req_best_move,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic [DepthWidth-1:0]         rsp_found_depth,
   output logic signed [ScoreWidth-1:0]  rsp_found_score,
   output logic [BoundWidth-1:0]         rsp_found_bound,
   output logic signed [MoveWidth-1:0]   rsp_found_move,
   output logic                          rsp_written,
   output logic [HitsWidth-1:0]          rsp_hits_total
);

   localparam int SlotCount = 1 << INDEX_BITS;

   slot_type slot_mem [SlotCount];

   logic [1:0]                   act_ff;
   logic [KeyWidth-1:0]          key_ff;
   logic [DepthWidth-1:0]        depth_ff;
   logic signed [ScoreWidth-1:0] score_ff;
   logic [BoundWidth-1:0]        bound_ff;
   logic signed [MoveWidth-1:0]  move_ff;
   slot_type                     rd_ff;

   logic [INDEX_BITS-1:0] sweep_ff;
   logic [INDEX_BITS-1:0] sweep_in;
   logic [HitsWidth-1:0]  hits_ff;
   logic [HitsWidth-1:0]  hits_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;

   logic                  hit;
   logic                  keep_old;
   logic                  do_store;
   logic                  wr_en;
   logic [INDEX_BITS-1:0] wr_addr;
   slot_type              wr_data;
   slot_type              new_slot;

   assign hit = (act_ff == ACT_PROBE) && rd_ff.valid && (rd_ff.key == key_ff);
   // depth-preferred: a deeper entry of another key survives
   assign keep_old = rd_ff.valid && (rd_ff.key != key_ff) && (rd_ff.depth > depth_ff);
   assign do_store = (act_ff == ACT_STORE) && !keep_old;

   always_comb begin
      new_slot.valid = 1'b1;
      new_slot.key   = key_ff;
      new_slot.depth = depth_ff;
      new_slot.score = score_ff;
      new_slot.bound = bound_ff;
      new_slot.move  = move_ff;
   end

   always_comb begin
      if (cmd.sweep) begin
         wr_en   = 1'b1;
         wr_addr = sweep_ff;
         wr_data = '0;
      end else begin
         wr_en   = cmd.commit && do_store;
         wr_addr = key_ff[INDEX_BITS-1:0];
         wr_data = new_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (cmd.accept) begin
         rd_ff <= slot_mem[req_position_key[INDEX_BITS-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         act_ff   <= req_action;
         key_ff   <= req_position_key;
         depth_ff <= req_search_depth;
         score_ff <= req_score_value;
         bound_ff <= req_bound_kind;
         move_ff  <= req_best_move;
      end
   end

   always_comb begin
      sweep_in = cmd.sweep ? sweep_ff + 1'b1 : sweep_ff;
      hits_in  = hits_ff;
      if (cmd.clear_hits) begin
         hits_in = '0;
      end else if (cmd.commit && hit && (hits_ff != '1)) begin
         hits_in = hits_ff + 1'b1;
      end
      rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= '0;
         hits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sweep_ff     <= sweep_in;
         hits_ff      <= hits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_found       <= hit;
         rsp_found_depth <= hit ? rd_ff.depth : '0;
         rsp_found_score <= hit ? rd_ff.score : '0;
         rsp_found_bound <= hit ? rd_ff.bound : '0;
         rsp_found_move  <= hit ? rd_ff.move : '0;
         rsp_written     <= do_store;
         rsp_hits_total  <= hits_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign status.sweep_last = (sweep_ff == '1);
   assign status.out_busy   = rsp_valid_ff && !rsp_ready;

endmodule

### hw/rtl/depth_preferred_hash_table_core.sv
// Direct-mapped table of 2^INDEX_BITS slots indexed by the low key bits, with
// depth-preferred replacement and a saturating probe hit counter. After reset
// the block sweeps the slot memory once with req_ready low. A probe or store
// runs accept and slot read, then compare, write-back and result load, before
// the next request is accepted; the compare step waits while the previous
// result sits untaken in the output register. A clear invalidates every slot,
// one slot invalidated per cycle.
module depth_preferred_hash_table_core
   import dpht_pkg::*;
#(
   parameter int INDEX_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_action,
   input  logic [KeyWidth-1:0]           req_position_key,
   input  logic [DepthWidth-1:0]         req_search_depth,
   input  logic signed [ScoreWidth-1:0]  req_score_value,
   input  logic [BoundWidth-1:0]         req_bound_kind,
   input  logic signed [MoveWidth-1:0]   req_best_move,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic [DepthWidth-1:0]         rsp_found_depth,
   output logic signed [ScoreWidth-1:0]  rsp_found_score,
   output logic [BoundWidth-1:0]         rsp_found_bound,
   output logic signed [MoveWidth-1:0]   rsp_found_move,
   output logic                          rsp_written,
   output logic [HitsWidth-1:0]          rsp_hits_total
);

   cmd_type    cmd;
   status_type status;

   dpht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .cmd        (cmd),
      .status     (status)
   );

   dpht_datapath #(
      .INDEX_BITS (INDEX_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_action       (req_action),
      .req_position_key (req_position_key),
      .req_search_depth (req_search_depth),
      .req_score_value  (req_score_value),
      .req_bound_kind   (req_bound_kind),
      .req_best_move    (req_best_move),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_found_depth  (rsp_found_depth),
      .rsp_found_score  (rsp_found_score),
      .rsp_found_bound  (rsp_found_bound),
      .rsp_found_move   (rsp_found_move),
      .rsp_written      (rsp_written),
      .rsp_hits_total   (rsp_hits_total)
   );

endmodule
